[hdl/mrc_pkg.sv]
package mrc_pkg;

    localparam int MRC_MAX_ELEMENTS    = 256;
    localparam int MRC_VALUE_WIDTH     = 32;
    localparam int MRC_ELEMENT_WIDTH   = 32;
    localparam int MRC_COUNT_OUT_WIDTH = 9;
    localparam int MRC_COUNT_LIMIT     = 511;
    localparam int MRC_M_TDATA_WIDTH   = 16;

    typedef struct packed {
        logic vld;
        logic done;
        logic last;
        logic drop;
    } mrc_ctl_t;

endpackage

[hdl/mrc_cell.sv]
module mrc_cell #(
    parameter int VALUE_WIDTH = 32,
    parameter int COUNT_WIDTH = 9
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  mrc_pkg::mrc_ctl_t      in_ctl,
    input  logic [VALUE_WIDTH-1:0] in_value,
    input  logic [COUNT_WIDTH-1:0] in_count,
    output mrc_pkg::mrc_ctl_t      out_ctl,
    output logic [VALUE_WIDTH-1:0] out_value,
    output logic [COUNT_WIDTH-1:0] out_count
);
    import mrc_pkg::*;

    logic                   occ_reg;
    logic                   occ_next;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [VALUE_WIDTH-1:0] val_next;
    logic [COUNT_WIDTH-1:0] cnt_reg;
    logic [COUNT_WIDTH-1:0] cnt_next;
    mrc_ctl_t               ctl_reg;
    mrc_ctl_t               ctl_next;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic                   live;
    logic                   match;
    logic                   claim;

    assign live  = in_ctl.vld && !in_ctl.done;
    assign match = live && occ_reg && (val_reg == in_value);
    assign claim = live && !occ_reg;

    always_comb begin
        occ_next   = occ_reg;
        val_next   = val_reg;
        cnt_next   = cnt_reg;
        ctl_next   = in_ctl;
        count_next = in_count;
        if (match) begin
            cnt_next      = cnt_reg + COUNT_WIDTH'(1);
            count_next    = cnt_next;
            ctl_next.done = 1'b1;
        end else if (claim) begin
            occ_next      = 1'b1;
            val_next      = in_value;
            cnt_next      = COUNT_WIDTH'(1);
            count_next    = COUNT_WIDTH'(1);
            ctl_next.done = 1'b1;
        end
        if (in_ctl.vld && in_ctl.last) begin
            occ_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
            ctl_reg <= '0;
        end else if (en) begin
            occ_reg <= occ_next;
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            val_reg   <= val_next;
            cnt_reg   <= cnt_next;
            value_reg <= in_value;
            count_reg <= count_next;
        end
    end

    assign out_ctl   = ctl_reg;
    assign out_value = value_reg;
    assign out_count = count_reg;

endmodule

[hdl/mrc_tail.sv]
module mrc_tail #(
    parameter int COUNT_WIDTH = 9
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  mrc_pkg::mrc_ctl_t                       in_ctl,
    input  logic [COUNT_WIDTH-1:0]                  in_count,
    output logic                                    hold,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [mrc_pkg::MRC_M_TDATA_WIDTH-1:0]   m_tdata
);
    import mrc_pkg::*;

    logic [COUNT_WIDTH-1:0]         best_reg;
    logic [COUNT_WIDTH-1:0]         best_next;
    logic                           ovf_reg;
    logic                           ovf_next;
    logic                           valid_reg;
    logic                           valid_next;
    logic [MRC_COUNT_OUT_WIDTH-1:0] count_reg;
    logic [MRC_COUNT_OUT_WIDTH-1:0] count_next;
    logic                           flag_reg;
    logic                           flag_next;
    logic [COUNT_WIDTH-1:0]         best_now;
    logic                           ovf_now;
    logic                           en;

    assign hold = in_ctl.vld && in_ctl.last && valid_reg && !m_tready;
    assign en   = !hold;

    always_comb begin
        best_now   = (in_count > best_reg) ? in_count : best_reg;
        ovf_now    = ovf_reg || in_ctl.drop;
        best_next  = best_reg;
        ovf_next   = ovf_reg;
        valid_next = valid_reg && !m_tready;
        count_next = count_reg;
        flag_next  = flag_reg;
        if (in_ctl.vld && en) begin
            best_next = best_now;
            ovf_next  = ovf_now;
            if (in_ctl.last) begin
                best_next  = '0;
                ovf_next   = 1'b0;
                valid_next = 1'b1;
                flag_next  = ovf_now;
                if (32'(best_now) > 32'(MRC_COUNT_LIMIT)) begin
                    count_next = MRC_COUNT_OUT_WIDTH'(MRC_COUNT_LIMIT);
                end else begin
                    count_next = MRC_COUNT_OUT_WIDTH'(best_now);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_reg  <= '0;
            ovf_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            best_reg  <= best_next;
            ovf_reg   <= ovf_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        count_reg <= count_next;
        flag_reg  <= flag_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = MRC_M_TDATA_WIDTH'({flag_reg, count_reg});

    property p_result_nonzero;
        @(posedge aclk) disable iff (!aresetn)
            valid_reg |-> (count_reg != '0);
    endproperty
    a_result_nonzero: assert property (p_result_nonzero)
        else $error("Result beat carries a zero count.");

    property p_best_cleared;
        @(posedge aclk) disable iff (!aresetn)
            (in_ctl.vld && in_ctl.last && en) |=> (best_reg == '0) && !ovf_reg;
    endproperty
    a_best_cleared: assert property (p_best_cleared)
        else $error("Running maximum not cleared after the end of a set.");

endmodule

[hdl/max_repeat_count_core.sv]
// Greatest repeat count of any value in a streamed set.
//
// The slave channel takes one element per beat; s_tlast marks the final
// element of a set. The master channel gives one beat per set, holding the
// largest number of times any single value occurred and an overflow flag.
//
// Each beat runs down a row of MAX_ELEMENTS compare cells, one cell per
// cycle unless the row holds. A cell keeps one distinct value and its
// count: a matching element increments it, the first free cell claims a
// new value. Elements beyond MAX_ELEMENTS in a set are not counted and
// raise the overflow flag. One beat is taken every cycle unless the row
// holds; the result is written to the output register once the last beat
// of its set has run through the whole cell row. The last beat clears
// each cell as it passes, so the next set may follow without a gap.
//
// Reset empties all cells and drops any pending result. If the receiver
// stalls, the row keeps moving until the end of another set reaches the
// output while a result is still waiting; then the whole row and s_tready
// hold until that result is taken.
module max_repeat_count_core #(
    parameter int MAX_ELEMENTS = mrc_pkg::MRC_MAX_ELEMENTS,
    parameter int VALUE_WIDTH  = mrc_pkg::MRC_VALUE_WIDTH
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // [31:0] element_value
    input  logic [mrc_pkg::MRC_ELEMENT_WIDTH-1:0]   s_tdata,
    input  logic                                    s_tlast,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // [8:0] max_count, [9] overflow, [15:10] zero
    output logic [mrc_pkg::MRC_M_TDATA_WIDTH-1:0]   m_tdata
);
    import mrc_pkg::*;

    localparam int COUNT_WIDTH = $clog2(MAX_ELEMENTS + 1);

    mrc_ctl_t                chain_ctl   [MAX_ELEMENTS+1];
    logic [VALUE_WIDTH-1:0]  chain_value [MAX_ELEMENTS+1];
    logic [COUNT_WIDTH-1:0]  chain_count [MAX_ELEMENTS+1];
    logic [COUNT_WIDTH-1:0]  taken_reg;
    logic [COUNT_WIDTH-1:0]  taken_next;
    logic signed [MRC_ELEMENT_WIDTH-1:0] element_s;
    logic                    hold;
    logic                    adv;
    logic                    accept;
    logic                    full;

    assign adv      = !hold;
    assign s_tready = adv;
    assign accept   = s_tvalid && adv;
    assign full     = (taken_reg == COUNT_WIDTH'(MAX_ELEMENTS));

    assign element_s = s_tdata;

    always_comb begin
        taken_next = taken_reg;
        if (accept) begin
            if (s_tlast) begin
                taken_next = '0;
            end else if (!full) begin
                taken_next = taken_reg + COUNT_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            taken_reg <= '0;
        end else begin
            taken_reg <= taken_next;
        end
    end

    always_comb begin
        chain_ctl[0].vld  = accept;
        chain_ctl[0].done = full;
        chain_ctl[0].last = s_tlast;
        chain_ctl[0].drop = full;
    end
    assign chain_value[0] = VALUE_WIDTH'(element_s);
    assign chain_count[0] = '0;

    for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
        mrc_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (adv),
            .in_ctl    (chain_ctl[i]),
            .in_value  (chain_value[i]),
            .in_count  (chain_count[i]),
            .out_ctl   (chain_ctl[i+1]),
            .out_value (chain_value[i+1]),
            .out_count (chain_count[i+1])
        );
    end

    mrc_tail #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_tail (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_ctl   (chain_ctl[MAX_ELEMENTS]),
        .in_count (chain_count[MAX_ELEMENTS]),
        .hold     (hold),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    property p_taken_bound;
        @(posedge aclk) disable iff (!aresetn)
            taken_reg <= COUNT_WIDTH'(MAX_ELEMENTS);
    endproperty
    a_taken_bound: assert property (p_taken_bound)
        else $error("Element counter ran past the cell count.");

    property p_all_placed;
        @(posedge aclk) disable iff (!aresetn)
            chain_ctl[MAX_ELEMENTS].vld |-> chain_ctl[MAX_ELEMENTS].done;
    endproperty
    a_all_placed: assert property (p_all_placed)
        else $error("Element left the cell row without being counted or dropped.");

    property p_drop_when_full;
        @(posedge aclk) disable iff (!aresetn)
            (accept && full) |=> (taken_reg == COUNT_WIDTH'(MAX_ELEMENTS))
                                 || $past(s_tlast);
    endproperty
    a_drop_when_full: assert property (p_drop_when_full)
        else $error("Element counter moved while the set was full.");

endmodule

[test/max_repeat_count_core_tb.sv]
`timescale 1ns / 100ps

module max_repeat_count_core_tb;

    import mrc_pkg::*;

    localparam int STALL_LIMIT  = 8 * (MRC_MAX_ELEMENTS + 1);
    localparam int RANDOM_ITEMS = 120;
    localparam int MIN_SETS     = 12;

    typedef struct {
        logic [MRC_COUNT_OUT_WIDTH-1:0] max_count;
        logic                           overflow;
    } tally_t;

    typedef enum int {
        POOL_NEAR,
        POOL_WIDE,
        POOL_EDGES
    } pool_t;

    logic                         aclk;
    logic                         aresetn  = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [MRC_ELEMENT_WIDTH-1:0] s_tdata  = '0;
    logic                         s_tlast  = 1'b0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [MRC_M_TDATA_WIDTH-1:0] m_tdata;

    logic steady = 1'b0;

    tally_t expected_tallies[$];
    tally_t arrived_tally;

    logic [MRC_VALUE_WIDTH-1:0] set_values[MRC_MAX_ELEMENTS];
    int                         set_counts[MRC_MAX_ELEMENTS];
    int                         set_used    = 0;
    int                         set_best    = 0;
    int                         set_taken   = 0;
    logic                       set_dropped = 1'b0;

    int error_count       = 0;
    int results_checked   = 0;
    int elements_accepted = 0;
    int sets_closed       = 0;
    int overflow_sets     = 0;
    int quiet_cycles      = 0;

    max_repeat_count_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic void tally_element(logic [MRC_ELEMENT_WIDTH-1:0] element,
                                          logic last_mark);
        logic [63:0]                widened;
        logic [MRC_VALUE_WIDTH-1:0] key;
        int                         hit;
        tally_t                     closing;
        widened = {{(64 - MRC_ELEMENT_WIDTH){element[MRC_ELEMENT_WIDTH-1]}}, element};
        key = widened[MRC_VALUE_WIDTH-1:0];
        elements_accepted++;
        if (set_taken < MRC_MAX_ELEMENTS) begin
            hit = set_used;
            for (int i = 0; i < set_used; i++) begin
                if (set_values[i] == key) begin
                    hit = i;
                    break;
                end
            end
            if (hit == set_used) begin
                set_values[hit] = key;
                set_counts[hit] = 0;
                set_used++;
            end
            set_counts[hit]++;
            if (set_counts[hit] > set_best) begin
                set_best = set_counts[hit];
            end
            set_taken++;
        end else begin
            set_dropped = 1'b1;
        end
        if (last_mark) begin
            closing.max_count = MRC_COUNT_OUT_WIDTH'((set_best > MRC_COUNT_LIMIT)
                                                     ? MRC_COUNT_LIMIT : set_best);
            closing.overflow  = set_dropped;
            expected_tallies.push_back(closing);
            sets_closed++;
            if (set_dropped) begin
                overflow_sets++;
            end
            set_used    = 0;
            set_best    = 0;
            set_taken   = 0;
            set_dropped = 1'b0;
        end
    endfunction

    function automatic logic [MRC_ELEMENT_WIDTH-1:0] random_element(pool_t pool,
                                                                   logic [31:0] base);
        case (pool)
            POOL_NEAR: return base + 32'($urandom_range(0, 3));
            POOL_WIDE: return 32'($urandom);
            default: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
        endcase
    endfunction

    task automatic send_element(input logic [MRC_ELEMENT_WIDTH-1:0] element,
                                input logic last_mark);
        while (!steady && $urandom_range(0, 99) < 34) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= element;
        s_tlast  <= last_mark;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        tally_element(element, last_mark);
    endtask

    task automatic send_set(input logic [MRC_ELEMENT_WIDTH-1:0] elements[$]);
        for (int i = 0; i < elements.size(); i++) begin
            send_element(elements[i], i == elements.size() - 1);
        end
    endtask

    task automatic send_random_set(input int length);
        pool_t       pool;
        logic [31:0] base;
        pool = pool_t'($urandom_range(0, 2));
        base = $urandom;
        for (int i = 0; i < length; i++) begin
            send_element(random_element(pool, base), i == length - 1);
        end
    endtask

    task automatic wait_for_results;
        s_tvalid <= 1'b0;
        while (expected_tallies.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic test_extremes;
        send_set('{32'h8000_0000});
        send_set('{32'h7FFF_FFFF});
        send_set('{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        send_set('{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555});
        send_set('{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000});
        send_set('{32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001});
        wait_for_results();
    endtask

    task automatic test_capacity;
        for (int i = 0; i <= MRC_MAX_ELEMENTS; i++) begin
            send_element((i < MRC_MAX_ELEMENTS) ? 32'(i) * 32'h0101_0101 : 32'h0,
                         i == MRC_MAX_ELEMENTS);
        end
        wait_for_results();
    endtask

    task automatic test_burst;
        steady <= 1'b1;
        for (int i = 0; i < 25; i++) begin
            send_random_set($urandom_range(1, 3));
        end
        steady <= 1'b0;
        wait_for_results();
    endtask

    task automatic test_random_sets;
        int items;
        int sets;
        int length;
        items = 0;
        sets  = 0;
        while (items < RANDOM_ITEMS || sets < MIN_SETS) begin
            length = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 12);
            send_random_set(length);
            items += length;
            sets++;
        end
        wait_for_results();
    endtask

    always @(posedge aclk) begin
        if (!aresetn || steady) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= 34);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_checked++;
            if (expected_tallies.size() == 0) begin
                $display("%0t: unexpected beat, expected none, got max_count %0d overflow %0b",
                         $time, m_tdata[MRC_COUNT_OUT_WIDTH-1:0], m_tdata[MRC_COUNT_OUT_WIDTH]);
                error_count++;
            end else begin
                arrived_tally = expected_tallies.pop_front();
                if (m_tdata[MRC_COUNT_OUT_WIDTH-1:0] !== arrived_tally.max_count) begin
                    $display("%0t: max_count expected %0d, got %0d", $time,
                             arrived_tally.max_count, m_tdata[MRC_COUNT_OUT_WIDTH-1:0]);
                    error_count++;
                end
                if (m_tdata[MRC_COUNT_OUT_WIDTH] !== arrived_tally.overflow) begin
                    $display("%0t: overflow expected %0b, got %0b", $time,
                             arrived_tally.overflow, m_tdata[MRC_COUNT_OUT_WIDTH]);
                    error_count++;
                end
                if (m_tdata[MRC_M_TDATA_WIDTH-1:MRC_COUNT_OUT_WIDTH+1] !== '0) begin
                    $display("%0t: padding expected 0, got %0h", $time,
                             m_tdata[MRC_M_TDATA_WIDTH-1:MRC_COUNT_OUT_WIDTH+1]);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
        end
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("max_repeat_count_core test failed");
        $finish;
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extremes();
        test_capacity();
        test_burst();
        test_random_sets();
        repeat (MRC_MAX_ELEMENTS + 16) @(posedge aclk);
        if (expected_tallies.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_tallies.size());
            error_count++;
        end
        $display("Ran %0d elements in %0d sets, %0d of them beyond capacity.",
                 elements_accepted, sets_closed, overflow_sets);
        $display("Checked %0d result beats under random stalls and one unbroken burst.",
                 results_checked);
        if (error_count == 0) begin
            $display("max_repeat_count_core test passed");
        end else begin
            $display("max_repeat_count_core test failed");
        end
        $finish;
    end

endmodule

[max_repeat_count_core.f]
hdl/mrc_pkg.sv
hdl/mrc_cell.sv
hdl/mrc_tail.sv
hdl/max_repeat_count_core.sv
test/max_repeat_count_core_tb.sv
